### hdl/uitp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uitp_pkg
// Shared widths, status codes and the result type for the unsigned integer
// text parser.
// ----------------------------------------------------------------------------
package uitp_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int CHAR_BITS   = 8;
   localparam int RADIX_BITS  = 6;
   localparam int VALUE_BITS  = 64;
   localparam int END_BITS    = 16;
   localparam int STATUS_BITS = 2;

   localparam logic [RADIX_BITS-1:0] MAX_BASE = 6'd36;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_BASE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE    = 2'd2;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  value;
      logic [END_BITS-1:0]    end_offset;
      logic                   digits_seen;
      logic [STATUS_BITS-1:0] status;
   } result_type;

endpackage

### hdl/uitp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uitp_core
// Parse state and combinational step logic: whitespace, sign, prefix, digit
// accumulation for one character per enabled cycle.
// ----------------------------------------------------------------------------
module uitp_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_en,
   input  logic [uitp_pkg::CHAR_BITS-1:0]     char_code,
   input  logic                               string_start,
   input  logic [uitp_pkg::RADIX_BITS-1:0]    radix,
   output logic                               emit,
   output uitp_pkg::result_type               result
);
   import uitp_pkg::*;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   saw_ff, saw_in;
   logic [RADIX_BITS-1:0]  base_ff, base_in;
   logic [OFFSET_BITS-1:0] idx_ff, idx_in;

   logic                   go_prefix;
   logic                   go_digit;
   logic                   advance;
   logic [STATUS_BITS-1:0] emit_status;
   logic [RADIX_BITS-1:0]  digit;
   logic [VALUE_BITS-1:0]  product;
   logic [31:0]            idx_wide;
   logic                   is_space;

   function automatic logic [RADIX_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
      logic [RADIX_BITS-1:0] d;
      d = 6'd63;
      if (c >= 8'd48 && c <= 8'd57) begin
         d = RADIX_BITS'(c - 8'd48);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         d = RADIX_BITS'(c - 8'd87);
      end else if (c >= 8'd65 && c <= 8'd90) begin
         d = RADIX_BITS'(c - 8'd55);
      end
      return d;
   endfunction

   assign digit    = digit_value(char_code);
   assign is_space = (char_code >= 8'd9 && char_code <= 8'd13) || char_code == 8'd32;

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      saw_in      = saw_ff;
      base_in     = base_ff;
      idx_in      = idx_ff;
      go_prefix   = 1'b0;
      go_digit    = 1'b0;
      advance     = 1'b0;
      emit        = 1'b0;
      emit_status = STATUS_OK;
      product     = '0;

      if (string_start) begin
         phase_in = PH_SPACE;
         acc_in   = '0;
         neg_in   = 1'b0;
         saw_in   = 1'b0;
         base_in  = '0;
         idx_in   = '0;
      end

      case (phase_in)
         PH_SPACE: begin
            if (idx_in == '0) begin
               base_in = radix;
               if (radix != '0 && (radix < 6'd2 || radix > MAX_BASE)) begin
                  emit        = 1'b1;
                  emit_status = STATUS_BAD_BASE;
               end
            end
            if (!emit) begin
               if (is_space) begin
                  advance = 1'b1;
               end else if (char_code == 8'd43 || char_code == 8'd45) begin
                  neg_in   = (char_code == 8'd45);
                  phase_in = PH_PREFIX;
                  advance  = 1'b1;
               end else begin
                  go_prefix = 1'b1;
               end
            end
         end
         PH_PREFIX: begin
            go_prefix = 1'b1;
         end
         PH_ZERO: begin
            if (char_code == 8'd120 || char_code == 8'd88) begin
               base_in  = 6'd16;
               phase_in = PH_DIGITS;
               advance  = 1'b1;
            end else begin
               if (base_in == '0) begin
                  base_in = 6'd8;
               end
               acc_in   = '0;
               saw_in   = 1'b1;
               go_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            go_digit = 1'b1;
         end
         default: begin
         end
      endcase

      if (go_prefix) begin
         if (char_code == 8'd48 && (base_in == '0 || base_in == 6'd16)) begin
            phase_in = PH_ZERO;
            advance  = 1'b1;
         end else begin
            if (base_in == '0) begin
               base_in = 6'd10;
            end
            go_digit = 1'b1;
         end
      end

      if (go_digit) begin
         phase_in = PH_DIGITS;
         if (char_code == '0 || digit >= base_in) begin
            emit = 1'b1;
         end else begin
            product = acc_in * VALUE_BITS'(base_in);
            acc_in  = product + VALUE_BITS'(digit);
            saw_in  = 1'b1;
            advance = 1'b1;
         end
      end

      if (advance && idx_in != '1) begin
         idx_in = idx_in + 1'b1;
      end

      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   assign idx_wide = 32'(idx_in);

   always_comb begin
      result.value       = '0;
      result.end_offset  = '0;
      result.digits_seen = 1'b0;
      result.status      = emit_status;
      if (emit_status == STATUS_OK && saw_in) begin
         result.end_offset  = idx_wide[END_BITS-1:0];
         result.digits_seen = 1'b1;
         if (neg_in) begin
            if (acc_in == '1) begin
               result.value  = '1;
               result.status = STATUS_RANGE;
            end else begin
               result.value = '0 - acc_in;
            end
         end else begin
            result.value = acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         saw_ff   <= 1'b0;
         base_ff  <= '0;
         idx_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         saw_ff   <= saw_in;
         base_ff  <= base_in;
         idx_ff   <= idx_in;
      end
   end

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff == PH_DONE && !string_start) |-> !emit)
      else $error("request after stop produced a response");

   a_no_digits_zero: assert property (@(posedge clock) disable iff (reset)
      (emit && !result.digits_seen) |-> (result.value == '0 && result.end_offset == '0))
      else $error("response without digits carries a value");

   a_range_all_ones: assert property (@(posedge clock) disable iff (reset)
      (emit && result.status == STATUS_RANGE) |-> (result.value == '1 && neg_in))
      else $error("range status without negated all-ones value");

endmodule

### hdl/uitp_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uitp_rsp_queue
// Two-entry response buffer that decouples the parser from the response
// handshake.
// ----------------------------------------------------------------------------
module uitp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  uitp_pkg::result_type push_item,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output uitp_pkg::result_type out_item
);
   import uitp_pkg::*;

   result_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("response queue overflow");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("response queue pointers disagree with count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("response queue count out of range");

endmodule

### hdl/unsigned_integer_text_parser_unit.sv
`timescale 1ns / 1ps
// Order: an accepted request is held in the input register until the parser
//   steps on it; its response, if any, then goes into the response buffer.
// Throughput: one request per cycle, set by the accumulator multiply-add loop,
//   while the two-entry response buffer (absorbing stalls) has room or drains.
// Reset: clears the parse state to the whitespace phase and the radix to 0.
// ----------------------------------------------------------------------------
// unsigned_integer_text_parser_unit
// Streaming text-to-unsigned converter taking one character per request and
// returning one response when the number ends.
// ----------------------------------------------------------------------------
module unsigned_integer_text_parser_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [uitp_pkg::RADIX_BITS-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [uitp_pkg::CHAR_BITS-1:0]      req_char_code,
   input  logic                                req_string_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [uitp_pkg::VALUE_BITS-1:0]     rsp_value,
   output logic [uitp_pkg::END_BITS-1:0]       rsp_end_offset,
   output logic                                rsp_digits_seen,
   output logic [uitp_pkg::STATUS_BITS-1:0]    rsp_status
);
   import uitp_pkg::*;

   logic [RADIX_BITS-1:0] radix_ff;
   logic                  in_valid_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  start_ff;
   logic                  step_fire;
   logic                  emit;
   logic                  queue_full;
   result_type            core_result;
   result_type            rsp_item;

   assign step_fire = in_valid_ff && (!queue_full || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            radix_ff <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (step_fire) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff  <= req_char_code;
         start_ff <= req_string_start;
      end
   end

   uitp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_fire),
      .char_code    (char_ff),
      .string_start (start_ff),
      .radix        (radix_ff),
      .emit         (emit),
      .result       (core_result)
   );

   uitp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_fire && emit),
      .push_item (core_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_value       = rsp_item.value;
   assign rsp_end_offset  = rsp_item.end_offset;
   assign rsp_digits_seen = rsp_item.digits_seen;
   assign rsp_status      = rsp_item.status;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unsigned integer text parser. Character
// requests stream in over a valid/ready channel while a scoreboard tracks
// whitespace, sign, radix prefix and digit accumulation, predicts each
// response and compares it field by field. Random gaps and stalls fall on
// both channels, and the radix register is swept while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import uitp_pkg::*;

   localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   class number_parse_scoreboard;
      typedef enum logic [2:0] {SKIP_SPACE, AFTER_SIGN, AFTER_ZERO, IN_DIGITS, STOPPED}
         stage_type;

      logic [RADIX_BITS-1:0]  radix;
      logic [RADIX_BITS-1:0]  base;
      stage_type              stage;
      logic [VALUE_BITS-1:0]  acc;
      logic                   neg;
      logic                   saw;
      logic [OFFSET_BITS-1:0] idx;
      result_type             expected_numbers[$];
      int                     failures;

      function new();
         radix = '0;
         failures = 0;
         clear_string();
      endfunction

      function void clear_string();
         stage = SKIP_SPACE;
         acc = '0;
         neg = 1'b0;
         saw = 1'b0;
         base = '0;
         idx = '0;
      endfunction

      function void write_radix(logic [RADIX_BITS-1:0] r);
         radix = r;
      endfunction

      function int pending();
         return expected_numbers.size();
      endfunction

      function void advance();
         if (idx != '1) idx++;
      endfunction

      function logic [RADIX_BITS-1:0] digit_of(logic [CHAR_BITS-1:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return RADIX_BITS'(c - CH_ZERO);
         if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return RADIX_BITS'(c - CH_LOWER_A + 10);
         if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return RADIX_BITS'(c - CH_UPPER_A + 10);
         return '1;
      endfunction

      function void emit(logic [STATUS_BITS-1:0] st);
         result_type r;
         r = '0;
         r.status = st;
         if (st == STATUS_OK && saw) begin
            r.end_offset = END_BITS'(idx);
            r.digits_seen = 1'b1;
            if (!neg) r.value = acc;
            else if (acc == '1) begin
               r.value = '1;
               r.status = STATUS_RANGE;
            end else r.value = -acc;
         end
         expected_numbers.push_back(r);
         stage = STOPPED;
      endfunction

      function void take_digit(logic [CHAR_BITS-1:0] c);
         logic [RADIX_BITS-1:0] d;
         d = digit_of(c);
         stage = IN_DIGITS;
         if (c == CH_NUL || d >= base) emit(STATUS_OK);
         else begin
            acc = acc * VALUE_BITS'(base) + VALUE_BITS'(d);
            saw = 1'b1;
            advance();
         end
      endfunction

      function void take_prefix(logic [CHAR_BITS-1:0] c);
         if (c == CH_ZERO && (base == 0 || base == 16)) begin
            stage = AFTER_ZERO;
            advance();
         end else begin
            if (base == 0) base = 10;
            take_digit(c);
         end
      endfunction

      function void note_request(logic [CHAR_BITS-1:0] c, logic start);
         if (start) clear_string();
         case (stage)
            SKIP_SPACE: begin
               if (idx == 0) begin
                  base = radix;
                  if (radix != 0 && (radix < 2 || radix > MAX_BASE)) begin
                     emit(STATUS_BAD_BASE);
                     return;
                  end
               end
               if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) advance();
               else if (c == CH_PLUS || c == CH_MINUS) begin
                  neg = (c == CH_MINUS);
                  stage = AFTER_SIGN;
                  advance();
               end else take_prefix(c);
            end
            AFTER_SIGN: take_prefix(c);
            AFTER_ZERO: begin
               if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                  base = 16;
                  stage = IN_DIGITS;
                  advance();
               end else begin
                  if (base == 0) base = 8;
                  acc = '0;
                  saw = 1'b1;
                  take_digit(c);
               end
            end
            IN_DIGITS: take_digit(c);
            default: ;
         endcase
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_numbers.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: value %h end %0d digits %0b status %0d",
                        got.value, got.end_offset, got.digits_seen, got.status);
            return;
         end
         want = expected_numbers.pop_front();
         if (got.value !== want.value || got.end_offset !== want.end_offset ||
             got.digits_seen !== want.digits_seen || got.status !== want.status) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected value %h end %0d digits %0b status %0d,",
                        want.value, want.end_offset, want.digits_seen, want.status);
               $display("          got value %h end %0d digits %0b status %0d",
                        got.value, got.end_offset, got.digits_seen, got.status);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [RADIX_BITS-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHAR_BITS-1:0]   req_char_code = '0;
   logic                   req_string_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [VALUE_BITS-1:0]  rsp_value;
   logic [END_BITS-1:0]    rsp_end_offset;
   logic                   rsp_digits_seen;
   logic [STATUS_BITS-1:0] rsp_status;

   number_parse_scoreboard sb;
   logic [CHAR_BITS:0]     item_q[$];
   logic                   first_item;
   int                     counted_items;
   logic [RADIX_BITS-1:0]  cur_radix = '0;
   bit                     steady = 1'b0;
   bit                     hold_request = 1'b0;
   int                     quiet_cycles = 0;

   unsigned_integer_text_parser_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_digits_seen  (rsp_digits_seen),
      .rsp_status       (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) quiet_cycles = 0;
      else begin
         if (csr_write_enable) sb.write_radix(csr_write_data);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_value, rsp_end_offset, rsp_digits_seen, rsp_status});
         if (req_valid && req_ready) sb.note_request(req_char_code, req_string_start);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb NOT OK");
               $finish;
            end
         end
      end
   end

   // response side: short and long stalls, plus one long hold-off on demand
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 39)
                                                     : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic start);
      int gap;
      req_valid <= 1'b1;
      req_char_code <= c;
      req_string_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      if (!steady && $urandom_range(0, 1) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic flush_items();
      logic [CHAR_BITS:0] it;
      while (item_q.size() != 0) begin
         it = item_q.pop_front();
         send_char(it[CHAR_BITS-1:0], it[CHAR_BITS]);
      end
   endtask

   function automatic void push_item(logic [CHAR_BITS-1:0] c);
      item_q.push_back({first_item, c});
      first_item = 1'b0;
      counted_items++;
   endfunction

   function automatic void push_text(string s, logic start, bit with_nul);
      first_item = start;
      for (int i = 0; i < s.len(); i++) push_item(s[i]);
      if (with_nul) push_item(CH_NUL);
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(int v);
      if (v < 10) return CH_ZERO + CHAR_BITS'(v);
      if ($urandom_range(0, 1) == 0) return CH_LOWER_A + CHAR_BITS'(v - 10);
      return CH_UPPER_A + CHAR_BITS'(v - 10);
   endfunction

   task automatic queue_random_string();
      int base;
      int n;
      int pick;
      int v;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) item_q.push_back({1'($urandom_range(0, 3) == 0), CHAR_BITS'($urandom)});
         return;
      end
      base = (cur_radix >= 2 && cur_radix <= MAX_BASE) ? int'(cur_radix) : 10;
      first_item = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            pick = $urandom_range(0, 5);
            push_item(pick == 5 ? CH_SPACE : CH_TAB + CHAR_BITS'(pick));
         end
      end
      pick = $urandom_range(0, 2);
      if (pick == 0) push_item(CH_PLUS);
      else if (pick == 1) push_item(CH_MINUS);
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         push_item(CH_ZERO);
         push_item($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
         if (cur_radix == 0 || cur_radix == 16) base = 16;
      end else if (pick == 1) begin
         push_item(CH_ZERO);
         if (cur_radix == 0) base = 8;
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (n) begin
         v = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 35) : $urandom_range(0, base - 1);
         push_item(digit_char(v));
      end
      push_item(($urandom_range(0, 2) == 0) ? CHAR_BITS'($urandom) : CH_NUL);
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 2);
         repeat (n) item_q.push_back({1'b0, CHAR_BITS'($urandom)});
      end
   endtask

   task automatic random_phase(input int target);
      counted_items = 0;
      while (counted_items < target) begin
         queue_random_string();
         flush_items();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_radix(input logic [RADIX_BITS-1:0] r);
      drain();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= r;
      cur_radix = r;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first string without a start flag, trailing character after the stop
      push_text(" +0x1Fg5", 1'b0, 1'b0);
      push_text("", 1'b1, 1'b1);
      push_text("-", 1'b1, 1'b1);
      push_text("0xg", 1'b1, 1'b0);
      push_text("\t-017", 1'b1, 1'b1);
      item_q.push_back({1'b1, 8'hFF});
      flush_items();
      random_phase(120);

      set_radix(6'd16);
      push_text("-ffffffffffffffff", 1'b1, 1'b1);
      push_text("-0X1", 1'b1, 1'b1);
      flush_items();
      random_phase(120);

      set_radix(6'd1);
      push_text("12", 1'b1, 1'b1);
      flush_items();
      random_phase(40);

      set_radix(6'd63);
      random_phase(40);

      set_radix(MAX_BASE);
      push_text("zZ", 1'b1, 1'b1);
      flush_items();
      random_phase(120);

      // hold off responses so the block backs up into the request side
      set_radix(6'd10);
      hold_request = 1'b1;
      repeat (16) push_text("7", 1'b1, 1'b1);
      flush_items();
      random_phase(120);
      push_text("12", 1'b1, 1'b0);
      flush_items();

      // radix stays latched for the string already under way
      set_radix(6'd2);
      push_text("9", 1'b0, 1'b1);
      flush_items();
      random_phase(120);

      set_radix(6'd8);
      random_phase(120);

      // no idling on either side
      set_radix(6'd0);
      steady = 1'b1;
      random_phase(100);
      steady = 1'b0;

      repeat (2) begin
         set_radix(RADIX_BITS'($urandom));
         random_phase(60);
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

### sim.f
hdl/uitp_pkg.sv
hdl/uitp_core.sv
hdl/uitp_rsp_queue.sv
hdl/unsigned_integer_text_parser_unit.sv
tb/tb.sv
